[sv/batch_to_space_address_map_macros.svh]
// Assertion macros used by the batch-to-space address map RTL.
// Define ASSERT_OFF to compile the assertions out.
`ifndef BATCH_TO_SPACE_ADDRESS_MAP_MACROS_SVH
`define BATCH_TO_SPACE_ADDRESS_MAP_MACROS_SVH
`ifndef ASSERT_OFF
// Checks an expression at every clock edge outside of reset.
`define B2S_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
// Checks that an antecedent is followed by a consequent in the next cycle, also in reset.
`define B2S_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);
`else
`define B2S_ASSERT(label, expr, msg)
`define B2S_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[sv/b2s_pkg.sv]
`default_nettype none
package b2s_pkg;

   // Field widths fixed by the register map and the item format.
   localparam int OB_W       = 11;
   localparam int BLK_W      = 7;
   localparam int CROP_W     = 12;
   localparam int EXT_W      = 13;
   localparam int BATCH_W    = 16;
   localparam int COORD_W    = 12;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int OUT_ADDR_W = 32;

   // Rebuilt spatial coordinate: coord * block + offset.
   localparam int Y_W = COORD_W + BLK_W;

   // Quotient bits resolved by one divider stage.
   localparam int DIV_STEPS = 4;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OUT_BATCH = 3'd0,
      CSR_BLOCK_H   = 3'd1,
      CSR_BLOCK_W   = 3'd2,
      CSR_CROP_TOP  = 3'd3,
      CSR_CROP_LEFT = 3'd4,
      CSR_OUT_H     = 3'd5,
      CSR_OUT_W     = 3'd6,
      CSR_CHANNELS  = 3'd7
   } csr_index_type;

   // Configuration as seen by the pipeline. Block sizes and batch count are never zero.
   typedef struct packed {
      logic [OB_W-1:0]   out_batch;
      logic [BLK_W-1:0]  block_h;
      logic [BLK_W-1:0]  block_w;
      logic [CROP_W-1:0] crop_top;
      logic [CROP_W-1:0] crop_left;
      logic [EXT_W-1:0]  out_h;
      logic [EXT_W-1:0]  out_w;
      logic [EXT_W-1:0]  channels;
   } csr_regs_type;

endpackage
`default_nettype wire

[sv/batch_to_space_address_map.sv]
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  batch_idx, row_idx, col_idx, chan_idx, element_value
// rsp       out        rsp_valid/rsp_ready  write_address, out_value
// csr       in         csr_write_en         csr_index, csr_data
//
// One item is accepted per cycle while the output is not stalled; a kept item is offered
// once it has passed two 16-bit dividers of four stages each, two coordinate stages
// and three multiply-add stages for the dense offset.
// Items in a cropped margin or with a batch index out of range are dropped in flight.
// Synchronous reset empties the pipeline and loads the register defaults.
// Each stage holds its item under stall, so upstream stages keep filling behind it.
`default_nettype none
`include "batch_to_space_address_map_macros.svh"
module batch_to_space_address_map #(
   parameter int DATA_BITS = 64,
   parameter int ADDR_BITS = 32,
   parameter int DIM_BITS  = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [b2s_pkg::BATCH_W-1:0]       req_batch_idx,
   input  logic [b2s_pkg::COORD_W-1:0]       req_row_idx,
   input  logic [b2s_pkg::COORD_W-1:0]       req_col_idx,
   input  logic [b2s_pkg::COORD_W-1:0]       req_chan_idx,
   input  logic [DATA_BITS-1:0]              req_element_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [b2s_pkg::OUT_ADDR_W-1:0]    rsp_write_address,
   output logic [DATA_BITS-1:0]              rsp_out_value,
   input  logic                              csr_write_en,
   input  b2s_pkg::csr_index_type            csr_index,
   input  logic [b2s_pkg::CSR_DATA_W-1:0]    csr_data
);

   import b2s_pkg::*;

   localparam logic [COORD_W-1:0] DIM_MASK =
      (DIM_BITS >= COORD_W) ? {COORD_W{1'b1}} : COORD_W'((1 << DIM_BITS) - 1);
   localparam int PAY_A_W = 3 * COORD_W + DATA_BITS;
   localparam int PAY_B_W = OB_W + PAY_A_W;

   csr_regs_type         csr_ff, csr_in;

   logic [PAY_A_W-1:0]   pay_a_in, pay_a_out;
   logic                 div_a_valid, div_a_ready;
   logic [BATCH_W-1:0]   quot_a;
   logic [OB_W-1:0]      rem_a;

   logic [PAY_B_W-1:0]   pay_b_out;
   logic                 div_b_valid, div_b_ready;
   logic [BATCH_W-1:0]   quot_b;
   logic [BLK_W-1:0]     rem_b;
   logic [OB_W-1:0]      n_b;
   logic [COORD_W-1:0]   row_b, col_b, chan_b;
   logic [DATA_BITS-1:0] value_b;

   logic                 crd_valid, crd_ready;
   logic [OB_W-1:0]      crd_n;
   logic [EXT_W-1:0]     crd_y, crd_x;
   logic [COORD_W-1:0]   crd_chan;
   logic [DATA_BITS-1:0] crd_value;

   logic [ADDR_BITS-1:0] addr;

   // Register writes. A zero batch count or block size is stored as one.
   always_comb begin
      csr_in = csr_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_OUT_BATCH: csr_in.out_batch =
               (csr_data[OB_W-1:0] == '0) ? OB_W'(1) : csr_data[OB_W-1:0];
            CSR_BLOCK_H:   csr_in.block_h =
               (csr_data[BLK_W-1:0] == '0) ? BLK_W'(1) : csr_data[BLK_W-1:0];
            CSR_BLOCK_W:   csr_in.block_w =
               (csr_data[BLK_W-1:0] == '0) ? BLK_W'(1) : csr_data[BLK_W-1:0];
            CSR_CROP_TOP:  csr_in.crop_top  = csr_data[CROP_W-1:0];
            CSR_CROP_LEFT: csr_in.crop_left = csr_data[CROP_W-1:0];
            CSR_OUT_H:     csr_in.out_h     = csr_data[EXT_W-1:0];
            CSR_OUT_W:     csr_in.out_w     = csr_data[EXT_W-1:0];
            CSR_CHANNELS:  csr_in.channels  = csr_data[EXT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.out_batch <= OB_W'(1);
         csr_ff.block_h   <= BLK_W'(1);
         csr_ff.block_w   <= BLK_W'(1);
         csr_ff.crop_top  <= '0;
         csr_ff.crop_left <= '0;
         csr_ff.out_h     <= EXT_W'(1);
         csr_ff.out_w     <= EXT_W'(1);
         csr_ff.channels  <= EXT_W'(1);
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Split the batch index: first by the output batch count, giving n as the remainder.
   assign pay_a_in = {req_row_idx & DIM_MASK, req_col_idx & DIM_MASK,
                      req_chan_idx & DIM_MASK, req_element_value};

   b2s_divider #(
      .NUM_W (BATCH_W),
      .DEN_W (OB_W),
      .PAY_W (PAY_A_W)
   ) u_div_batch (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .den       (csr_ff.out_batch),
      .dividend  (req_batch_idx),
      .src_pay   (pay_a_in),
      .out_valid (div_a_valid),
      .out_ready (div_a_ready),
      .quotient  (quot_a),
      .remainder (rem_a),
      .dst_pay   (pay_a_out)
   );

   // Then by block_w, giving the row offset as quotient and the column offset as remainder.
   b2s_divider #(
      .NUM_W (BATCH_W),
      .DEN_W (BLK_W),
      .PAY_W (PAY_B_W)
   ) u_div_block (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_a_valid),
      .in_ready  (div_a_ready),
      .den       (csr_ff.block_w),
      .dividend  (quot_a),
      .src_pay   ({rem_a, pay_a_out}),
      .out_valid (div_b_valid),
      .out_ready (div_b_ready),
      .quotient  (quot_b),
      .remainder (rem_b),
      .dst_pay   (pay_b_out)
   );

   assign {n_b, row_b, col_b, chan_b, value_b} = pay_b_out;

   // Spatial rebuild and cropping.
   b2s_coord #(
      .DATA_BITS (DATA_BITS)
   ) u_coord (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .in_valid  (div_b_valid),
      .in_ready  (div_b_ready),
      .r0        (quot_b),
      .r1        (rem_b),
      .src_n     (n_b),
      .src_row   (row_b),
      .src_col   (col_b),
      .src_chan  (chan_b),
      .src_value (value_b),
      .out_valid (crd_valid),
      .out_ready (crd_ready),
      .dst_n     (crd_n),
      .dst_y     (crd_y),
      .dst_x     (crd_x),
      .dst_chan  (crd_chan),
      .dst_value (crd_value)
   );

   // Dense row-major output offset; the last stage is the output register.
   b2s_offset #(
      .DATA_BITS (DATA_BITS),
      .ADDR_BITS (ADDR_BITS)
   ) u_offset (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .in_valid  (crd_valid),
      .in_ready  (crd_ready),
      .src_n     (crd_n),
      .src_y     (crd_y),
      .src_x     (crd_x),
      .src_chan  (crd_chan),
      .src_value (crd_value),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .dst_addr  (addr),
      .dst_value (rsp_out_value)
   );

   assign rsp_write_address = OUT_ADDR_W'(addr);

   // Assertions.
   `B2S_ASSERT(a_divisor_nonzero, csr_ff.out_batch != '0 && csr_ff.block_w != '0 && csr_ff.block_h != '0, "zero divisor or block size stored")
   `B2S_ASSERT(a_ready_chain, !rsp_ready || req_ready, "input stalled while the output drains")
   `B2S_ASSERT_NEXT(a_reset_flush, reset, !rsp_valid, "result shown right after reset")

endmodule
`default_nettype wire

[sv/b2s_div_stage.sv]
`default_nettype none
module b2s_div_stage #(
   parameter int NUM_W = 16,
   parameter int DEN_W = 11,
   parameter int STEPS = 4,
   parameter int PAY_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [DEN_W-1:0] den,
   input  logic [DEN_W:0]   src_rem,
   input  logic [NUM_W-1:0] src_acc,
   input  logic [PAY_W-1:0] src_pay,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [DEN_W:0]   dst_rem,
   output logic [NUM_W-1:0] dst_acc,
   output logic [PAY_W-1:0] dst_pay
);

   logic             valid_ff;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [NUM_W-1:0] acc_ff, acc_in;
   logic [PAY_W-1:0] pay_ff;

   // Restoring division steps: shift the next dividend bit into the remainder,
   // subtract the divisor where it fits and shift the quotient bit in.
   always_comb begin
      rem_in = src_rem;
      acc_in = src_acc;
      for (int i = 0; i < STEPS; i++) begin
         rem_in = {rem_in[DEN_W-1:0], acc_in[NUM_W-1]};
         acc_in = {acc_in[NUM_W-2:0], 1'b0};
         if (rem_in >= {1'b0, den}) begin
            rem_in    = rem_in - {1'b0, den};
            acc_in[0] = 1'b1;
         end
      end
   end

   // The stage takes an item when it is empty or its item moves on.
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rem_ff <= rem_in;
         acc_ff <= acc_in;
         pay_ff <= src_pay;
      end
   end

   assign out_valid = valid_ff;
   assign dst_rem   = rem_ff;
   assign dst_acc   = acc_ff;
   assign dst_pay   = pay_ff;

endmodule
`default_nettype wire

[sv/b2s_divider.sv]
`default_nettype none
module b2s_divider #(
   parameter int NUM_W = 16,
   parameter int DEN_W = 11,
   parameter int PAY_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [DEN_W-1:0] den,
   input  logic [NUM_W-1:0] dividend,
   input  logic [PAY_W-1:0] src_pay,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [NUM_W-1:0] quotient,
   output logic [DEN_W-1:0] remainder,
   output logic [PAY_W-1:0] dst_pay
);

   import b2s_pkg::*;

   localparam int STAGES = NUM_W / DIV_STEPS;

   logic             vld [0:STAGES];
   logic             rdy [0:STAGES];
   logic [DEN_W:0]   rem [0:STAGES];
   logic [NUM_W-1:0] acc [0:STAGES];
   logic [PAY_W-1:0] pay [0:STAGES];

   // Entry of the chain: remainder starts at zero, the dividend sits in the accumulator.
   assign vld[0]   = in_valid;
   assign in_ready = rdy[0];
   assign rem[0]   = '0;
   assign acc[0]   = dividend;
   assign pay[0]   = src_pay;

   // A chain of stages, each resolving a few quotient bits.
   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      b2s_div_stage #(
         .NUM_W (NUM_W),
         .DEN_W (DEN_W),
         .STEPS (DIV_STEPS),
         .PAY_W (PAY_W)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld[g]),
         .in_ready  (rdy[g]),
         .den       (den),
         .src_rem   (rem[g]),
         .src_acc   (acc[g]),
         .src_pay   (pay[g]),
         .out_valid (vld[g+1]),
         .out_ready (rdy[g+1]),
         .dst_rem   (rem[g+1]),
         .dst_acc   (acc[g+1]),
         .dst_pay   (pay[g+1])
      );
   end

   assign out_valid   = vld[STAGES];
   assign rdy[STAGES] = out_ready;
   assign quotient    = acc[STAGES];
   assign remainder   = rem[STAGES][DEN_W-1:0];
   assign dst_pay     = pay[STAGES];

endmodule
`default_nettype wire

[sv/b2s_coord.sv]
`default_nettype none
module b2s_coord #(
   parameter int DATA_BITS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  b2s_pkg::csr_regs_type          csr,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [b2s_pkg::BATCH_W-1:0]    r0,
   input  logic [b2s_pkg::BLK_W-1:0]      r1,
   input  logic [b2s_pkg::OB_W-1:0]       src_n,
   input  logic [b2s_pkg::COORD_W-1:0]    src_row,
   input  logic [b2s_pkg::COORD_W-1:0]    src_col,
   input  logic [b2s_pkg::COORD_W-1:0]    src_chan,
   input  logic [DATA_BITS-1:0]           src_value,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [b2s_pkg::OB_W-1:0]       dst_n,
   output logic [b2s_pkg::EXT_W-1:0]      dst_y,
   output logic [b2s_pkg::EXT_W-1:0]      dst_x,
   output logic [b2s_pkg::COORD_W-1:0]    dst_chan,
   output logic [DATA_BITS-1:0]           dst_value
);

   import b2s_pkg::*;

   logic                 rebuild_valid_ff, rebuild_ready, batch_keep;
   logic [Y_W-1:0]       y_ff, y_in, x_ff, x_in;
   logic [OB_W-1:0]      n_ff;
   logic [COORD_W-1:0]   chan_ff;
   logic [DATA_BITS-1:0] value_ff;

   logic                 crop_valid_ff, crop_ready, crop_keep;
   logic [Y_W-1:0]       ys_in, xs_in;
   logic [EXT_W-1:0]     ys_ff, xs_ff;
   logic [OB_W-1:0]      n2_ff;
   logic [COORD_W-1:0]   chan2_ff;
   logic [DATA_BITS-1:0] value2_ff;

   // A row offset at or past block_h means the batch index was out of range.
   assign batch_keep = r0 < BATCH_W'(csr.block_h);

   // Rebuild the spatial position from the coordinate and the block offset.
   assign y_in = Y_W'(src_row) * Y_W'(csr.block_h) + Y_W'(r0[BLK_W-1:0]);
   assign x_in = Y_W'(src_col) * Y_W'(csr.block_w) + Y_W'(r1);

   assign crop_ready    = !crop_valid_ff || out_ready;
   assign rebuild_ready = !rebuild_valid_ff || crop_ready;
   assign in_ready      = rebuild_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rebuild_valid_ff <= 1'b0;
      end else if (rebuild_ready) begin
         rebuild_valid_ff <= in_valid && batch_keep;
      end
   end

   always_ff @(posedge clock) begin
      if (rebuild_ready && in_valid) begin
         y_ff     <= y_in;
         x_ff     <= x_in;
         n_ff     <= src_n;
         chan_ff  <= src_chan;
         value_ff <= src_value;
      end
   end

   // Remove the crops; items in a cropped margin leave the pipeline here.
   assign ys_in     = y_ff - Y_W'(csr.crop_top);
   assign xs_in     = x_ff - Y_W'(csr.crop_left);
   assign crop_keep = (y_ff >= Y_W'(csr.crop_top)) && (x_ff >= Y_W'(csr.crop_left))
                      && (ys_in < Y_W'(csr.out_h)) && (xs_in < Y_W'(csr.out_w));

   always_ff @(posedge clock) begin
      if (reset) begin
         crop_valid_ff <= 1'b0;
      end else if (crop_ready) begin
         crop_valid_ff <= rebuild_valid_ff && crop_keep;
      end
   end

   always_ff @(posedge clock) begin
      if (crop_ready && rebuild_valid_ff) begin
         ys_ff     <= ys_in[EXT_W-1:0];
         xs_ff     <= xs_in[EXT_W-1:0];
         n2_ff     <= n_ff;
         chan2_ff  <= chan_ff;
         value2_ff <= value_ff;
      end
   end

   assign out_valid = crop_valid_ff;
   assign dst_n     = n2_ff;
   assign dst_y     = ys_ff;
   assign dst_x     = xs_ff;
   assign dst_chan  = chan2_ff;
   assign dst_value = value2_ff;

endmodule
`default_nettype wire

[sv/b2s_offset.sv]
`default_nettype none
module b2s_offset #(
   parameter int DATA_BITS = 64,
   parameter int ADDR_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  b2s_pkg::csr_regs_type       csr,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [b2s_pkg::OB_W-1:0]    src_n,
   input  logic [b2s_pkg::EXT_W-1:0]   src_y,
   input  logic [b2s_pkg::EXT_W-1:0]   src_x,
   input  logic [b2s_pkg::COORD_W-1:0] src_chan,
   input  logic [DATA_BITS-1:0]        src_value,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [ADDR_BITS-1:0]        dst_addr,
   output logic [DATA_BITS-1:0]        dst_value
);

   import b2s_pkg::*;

   logic [2:0]           valid_ff;
   logic [2:0]           ready;
   logic [ADDR_BITS-1:0] t1_ff, t1_in, t2_ff, t2_in, addr_ff, addr_in;
   logic [EXT_W-1:0]     x_ff;
   logic [COORD_W-1:0]   chan1_ff, chan2_ff;
   logic [DATA_BITS-1:0] value1_ff, value2_ff, value3_ff;

   // Each stage moves on when it is empty or the one after it moves on.
   assign ready[2] = !valid_ff[2] || out_ready;
   assign ready[1] = !valid_ff[1] || ready[2];
   assign ready[0] = !valid_ff[0] || ready[1];
   assign in_ready = ready[0];

   // One multiply-add per stage, all modulo the address width.
   assign t1_in   = ADDR_BITS'(src_n) * ADDR_BITS'(csr.out_h) + ADDR_BITS'(src_y);
   assign t2_in   = t1_ff * ADDR_BITS'(csr.out_w) + ADDR_BITS'(x_ff);
   assign addr_in = t2_ff * ADDR_BITS'(csr.channels) + ADDR_BITS'(chan2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) begin
            valid_ff[0] <= in_valid;
         end
         if (ready[1]) begin
            valid_ff[1] <= valid_ff[0];
         end
         if (ready[2]) begin
            valid_ff[2] <= valid_ff[1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0] && in_valid) begin
         t1_ff     <= t1_in;
         x_ff      <= src_x;
         chan1_ff  <= src_chan;
         value1_ff <= src_value;
      end
      if (ready[1] && valid_ff[0]) begin
         t2_ff     <= t2_in;
         chan2_ff  <= chan1_ff;
         value2_ff <= value1_ff;
      end
      if (ready[2] && valid_ff[1]) begin
         addr_ff   <= addr_in;
         value3_ff <= value2_ff;
      end
   end

   assign out_valid = valid_ff[2];
   assign dst_addr  = addr_ff;
   assign dst_value = value3_ff;

endmodule
`default_nettype wire

[sim/b2s_placement_checker.sv]
`default_nettype none
// Watches the register port and both item channels of the address map. It keeps its own
// copy of the registers, works out where each accepted element lands, and compares
// every returned item against the oldest placement still due.
module b2s_placement_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_ready,
   input  wire logic [b2s_pkg::BATCH_W-1:0]         req_batch_idx,
   input  wire logic [b2s_pkg::COORD_W-1:0]         req_row_idx,
   input  wire logic [b2s_pkg::COORD_W-1:0]         req_col_idx,
   input  wire logic [b2s_pkg::COORD_W-1:0]         req_chan_idx,
   input  wire logic [63:0]                         req_element_value,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire logic [b2s_pkg::OUT_ADDR_W-1:0]      rsp_write_address,
   input  wire logic [63:0]                         rsp_out_value,
   input  wire logic                                csr_write_en,
   input  wire b2s_pkg::csr_index_type              csr_index,
   input  wire logic [b2s_pkg::CSR_DATA_W-1:0]      csr_data,
   output int                                       mismatches,
   output int                                       placements_outstanding,
   output int                                       placed_count,
   output int                                       dropped_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [b2s_pkg::OUT_ADDR_W-1:0] write_address;
      logic [63:0]                    out_value;
   } placement_type;

   placement_type         placements_due[$];
   b2s_pkg::csr_regs_type regs;

   // Works out the dense output offset of one element; returns 0 when it is dropped.
   function automatic bit map_element(input logic [b2s_pkg::BATCH_W-1:0] batch,
                                      input logic [b2s_pkg::COORD_W-1:0] row,
                                      input logic [b2s_pkg::COORD_W-1:0] col,
                                      input logic [b2s_pkg::COORD_W-1:0] chan,
                                      output logic [b2s_pkg::OUT_ADDR_W-1:0] address);
      longint unsigned ob, bh, bw, n, q, r0, r1, y, x, offset;
      longint unsigned ct, cl, oh, ow, ch;
      address = '0;
      // A zero in a count or block register behaves as one.
      ob = (regs.out_batch == '0) ? 64'd1 : 64'(regs.out_batch);
      bh = (regs.block_h == '0) ? 64'd1 : 64'(regs.block_h);
      bw = (regs.block_w == '0) ? 64'd1 : 64'(regs.block_w);
      ct = 64'(regs.crop_top);
      cl = 64'(regs.crop_left);
      oh = 64'(regs.out_h);
      ow = 64'(regs.out_w);
      ch = 64'(regs.channels);
      if (64'(batch) >= ob * bh * bw) return 1'b0;
      // The batch index splits as ((r0 * bw + r1) * ob + n).
      n  = 64'(batch) % ob;
      q  = 64'(batch) / ob;
      r1 = q % bw;
      r0 = q / bw;
      y  = 64'(row) * bh + r0;
      x  = 64'(col) * bw + r1;
      if (y < ct || x < cl) return 1'b0;
      y = y - ct;
      x = x - cl;
      if (y >= oh || x >= ow) return 1'b0;
      // The channel is not range checked, and the offset wraps at the address width.
      offset  = ((n * oh + y) * ow + x) * ch + 64'(chan);
      address = offset[b2s_pkg::OUT_ADDR_W-1:0];
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      placement_type                  want;
      logic [b2s_pkg::OUT_ADDR_W-1:0] address;
      if (reset) begin
         regs = '{out_batch: 1, block_h: 1, block_w: 1, crop_top: 0, crop_left: 0,
                  out_h: 1, out_w: 1, channels: 1};
         placements_due.delete();
         mismatches    = 0;
         placed_count  = 0;
         dropped_count = 0;
      end else begin
         // Track register writes so that later items are mapped with the new setting.
         if (csr_write_en) begin
            case (csr_index)
               b2s_pkg::CSR_OUT_BATCH: regs.out_batch = csr_data[b2s_pkg::OB_W-1:0];
               b2s_pkg::CSR_BLOCK_H:   regs.block_h   = csr_data[b2s_pkg::BLK_W-1:0];
               b2s_pkg::CSR_BLOCK_W:   regs.block_w   = csr_data[b2s_pkg::BLK_W-1:0];
               b2s_pkg::CSR_CROP_TOP:  regs.crop_top  = csr_data[b2s_pkg::CROP_W-1:0];
               b2s_pkg::CSR_CROP_LEFT: regs.crop_left = csr_data[b2s_pkg::CROP_W-1:0];
               b2s_pkg::CSR_OUT_H:     regs.out_h     = csr_data[b2s_pkg::EXT_W-1:0];
               b2s_pkg::CSR_OUT_W:     regs.out_w     = csr_data[b2s_pkg::EXT_W-1:0];
               b2s_pkg::CSR_CHANNELS:  regs.channels  = csr_data[b2s_pkg::EXT_W-1:0];
               default: ;
            endcase
         end

         // Compare a returned item with the oldest placement still due.
         if (rsp_valid && rsp_ready) begin
            if (placements_due.size() == 0) begin
               $error("unexpected item: write_address %h, out_value %h",
                      rsp_write_address, rsp_out_value);
               mismatches++;
            end else begin
               want = placements_due.pop_front();
               if (rsp_write_address !== want.write_address) begin
                  $error("write_address: expected %h, actual %h",
                         want.write_address, rsp_write_address);
                  mismatches++;
               end
               if (rsp_out_value !== want.out_value) begin
                  $error("out_value: expected %h, actual %h", want.out_value, rsp_out_value);
                  mismatches++;
               end
            end
         end

         // Each accepted element either lands somewhere or is dropped.
         if (req_valid && req_ready) begin
            if (map_element(req_batch_idx, req_row_idx, req_col_idx, req_chan_idx,
                            address)) begin
               want.write_address = address;
               want.out_value     = req_element_value;
               placements_due     = {placements_due, want};
               placed_count++;
            end else begin
               dropped_count++;
            end
         end
      end
      placements_outstanding = placements_due.size();
   end

endmodule
`default_nettype wire

[sim/testbench.sv]
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import b2s_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int DRAIN_CYCLES    = 32;
   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 96;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [BATCH_W-1:0]     req_batch_idx;
   logic [COORD_W-1:0]     req_row_idx;
   logic [COORD_W-1:0]     req_col_idx;
   logic [COORD_W-1:0]     req_chan_idx;
   logic [63:0]            req_element_value;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [OUT_ADDR_W-1:0]  rsp_write_address;
   logic [63:0]            rsp_out_value;
   logic                   csr_write_en;
   csr_index_type          csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   int mismatches;
   int placements_outstanding;
   int placed_count;
   int dropped_count;

   csr_regs_type cur_cfg;
   int           tx_idle_pct = 12;
   int           rx_idle_pct = 67;
   int           items_sent = 0;
   int           settings_used = 0;
   int           cycles = 0;

   batch_to_space_address_map DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_batch_idx     (req_batch_idx),
      .req_row_idx       (req_row_idx),
      .req_col_idx       (req_col_idx),
      .req_chan_idx      (req_chan_idx),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_write_address (rsp_write_address),
      .rsp_out_value     (rsp_out_value),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   b2s_placement_checker placement_check (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_batch_idx          (req_batch_idx),
      .req_row_idx            (req_row_idx),
      .req_col_idx            (req_col_idx),
      .req_chan_idx           (req_chan_idx),
      .req_element_value      (req_element_value),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_write_address      (rsp_write_address),
      .rsp_out_value          (rsp_out_value),
      .csr_write_en           (csr_write_en),
      .csr_index              (csr_index),
      .csr_data               (csr_data),
      .mismatches             (mismatches),
      .placements_outstanding (placements_outstanding),
      .placed_count           (placed_count),
      .dropped_count          (dropped_count)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // The receiver stalls at random at the current idle rate.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   function automatic csr_regs_type make_cfg(int ob, int bh, int bw, int ct, int cl,
                                             int oh, int ow, int ch);
      csr_regs_type cfg;
      cfg.out_batch = OB_W'(ob);
      cfg.block_h   = BLK_W'(bh);
      cfg.block_w   = BLK_W'(bw);
      cfg.crop_top  = CROP_W'(ct);
      cfg.crop_left = CROP_W'(cl);
      cfg.out_h     = EXT_W'(oh);
      cfg.out_w     = EXT_W'(ow);
      cfg.channels  = EXT_W'(ch);
      return cfg;
   endfunction

   // Register value: the low end, a small value, anything in range, or the high end.
   function automatic int rand_reg(int lo, int mid, int hi);
      case ($urandom_range(3))
         0:       return lo;
         1:       return $urandom_range(mid, lo);
         2:       return $urandom_range(hi, lo);
         default: return hi;
      endcase
   endfunction

   // Picks an input coordinate whose rebuilt position falls inside the kept window, or any coordinate when none does.
   function automatic int pick_coord(int crop, int extent, int blk, int off);
      int lo, hi;
      if (crop + extent - 1 < off) return $urandom_range(4095);
      lo = (crop > off) ? (crop - off + blk - 1) / blk : 0;
      hi = (crop + extent - 1 - off) / blk;
      if (hi > 4095) hi = 4095;
      if (lo > hi) return $urandom_range(4095);
      return $urandom_range(hi, lo);
   endfunction

   // Offers one item, possibly after some idle cycles, and holds it until accepted.
   task automatic send_item(input int batch, input int row, input int col, input int chan,
                            input logic [63:0] value);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_batch_idx     <= BATCH_W'(batch);
      req_row_idx       <= COORD_W'(row);
      req_col_idx       <= COORD_W'(col);
      req_chan_idx      <= COORD_W'(chan);
      req_element_value <= value;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   // Stops sending until every placement due has come back.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (placements_outstanding != 0);
   endtask

   // Lets dropped items still in flight leave the pipeline too.
   task automatic settle();
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic load_config(input csr_regs_type cfg);
      csr_index_type         idx;
      logic [CSR_DATA_W-1:0] value;
      settle();
      idx = idx.first();
      repeat (idx.num()) begin
         case (idx)
            CSR_OUT_BATCH: value = CSR_DATA_W'(cfg.out_batch);
            CSR_BLOCK_H:   value = CSR_DATA_W'(cfg.block_h);
            CSR_BLOCK_W:   value = CSR_DATA_W'(cfg.block_w);
            CSR_CROP_TOP:  value = CSR_DATA_W'(cfg.crop_top);
            CSR_CROP_LEFT: value = CSR_DATA_W'(cfg.crop_left);
            CSR_OUT_H:     value = cfg.out_h;
            CSR_OUT_W:     value = cfg.out_w;
            default:       value = cfg.channels;
         endcase
         csr_write_en <= 1'b1;
         csr_index    <= idx;
         csr_data     <= value;
         @(negedge clock);
         idx = idx.next();
      end
      csr_write_en <= 1'b0;
      cur_cfg = cfg;
      settings_used++;
   endtask

   // Mostly elements that land in the kept window, the rest arbitrary coordinates.
   task automatic send_random_item();
      int ob, bh, bw, span, b, q, r0, r1;
      if ($urandom_range(3) == 0) begin
         send_item($urandom, $urandom, $urandom, $urandom, {$urandom, $urandom});
      end else begin
         ob   = (cur_cfg.out_batch == '0) ? 1 : int'(cur_cfg.out_batch);
         bh   = (cur_cfg.block_h == '0) ? 1 : int'(cur_cfg.block_h);
         bw   = (cur_cfg.block_w == '0) ? 1 : int'(cur_cfg.block_w);
         span = ob * bh * bw;
         if (span > 65536) span = 65536;
         b  = $urandom_range(span - 1);
         q  = b / ob;
         r1 = q % bw;
         r0 = q / bw;
         send_item(b, pick_coord(int'(cur_cfg.crop_top), int'(cur_cfg.out_h), bh, r0),
                   pick_coord(int'(cur_cfg.crop_left), int'(cur_cfg.out_w), bw, r1),
                   $urandom, {$urandom, $urandom});
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_batch_idx     = '0;
      req_row_idx       = '0;
      req_col_idx       = '0;
      req_chan_idx      = '0;
      req_element_value = '0;
      rsp_ready         = 1'b0;
      csr_write_en      = 1'b0;
      csr_index         = CSR_OUT_BATCH;
      csr_data          = '0;
      cur_cfg           = make_cfg(1, 1, 1, 0, 0, 1, 1, 1);
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Register defaults: a single kept row and column position for any channel, everything else dropped.
      send_item(0, 0, 0, 0, 64'h0);
      send_item(0, 0, 0, 4095, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(1, 0, 0, 0, 64'h1);
      send_item(0, 1, 0, 0, 64'h2);
      send_item(0, 0, 1, 0, 64'h3);

      // Small setting with both crops: window edges, margins and batch range.
      load_config(make_cfg(3, 2, 3, 1, 2, 5, 7, 4));
      send_item(17, 0, 0, 1, 64'hA5A5_0000_FFFF_5A5A);
      send_item(18, 0, 0, 0, 64'h4);
      send_item(0, 0, 0, 0, 64'h5);
      send_item(3, 1, 0, 0, 64'h6);
      send_item(17, 2, 2, 3, 64'h7);
      send_item(17, 3, 2, 0, 64'h8);
      send_item(17, 2, 3, 0, 64'h9);
      send_item(65535, 0, 0, 0, 64'hA);
      send_item(0, 4095, 4095, 4095, 64'hB);

      // Zero counts and blocks act as one; the largest offset wraps the address.
      load_config(make_cfg(0, 0, 0, 0, 0, 4096, 4096, 4096));
      send_item(0, 4095, 4095, 4095, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(1, 0, 0, 0, 64'hC);
      send_item(0, 0, 0, 0, 64'hD);
      send_item(0, 4095, 0, 0, 64'hE);

      // Largest values of the random register ranges everywhere.
      load_config(make_cfg(1024, 64, 64, 4095, 4095, 4096, 4096, 4096));
      send_item(65535, 4095, 4095, 4095, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(65535, 64, 64, 4095, 64'h0123_4567_89AB_CDEF);
      send_item(0, 63, 63, 0, 64'hF);

      // Random phases: sender idles lightly, then the receiver, then neither.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase / 4)
            0:       begin tx_idle_pct = 12; rx_idle_pct = 67; end
            1:       begin tx_idle_pct = 67; rx_idle_pct = 12; end
            default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
         endcase
         case (phase % 4)
            0: load_config(make_cfg(1024, 64, 64, 4095, 4095, 4096, 4096, 4096));
            1: load_config(make_cfg(1, 1, 1, 0, 0, 1, 1, 1));
            default: load_config(make_cfg(rand_reg(0, 8, 1024), rand_reg(0, 4, 64),
                                          rand_reg(0, 4, 64), rand_reg(0, 15, 4095),
                                          rand_reg(0, 15, 4095), rand_reg(1, 32, 4096),
                                          rand_reg(1, 32, 4096), rand_reg(1, 16, 4096)));
         endcase
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // Halfway through, let the pipeline run completely dry once.
            if (i == ITEMS_PER_PHASE / 2) hold_until_drained();
            send_random_item();
         end
      end

      settle();
      $display("Sent %0d items under %0d register settings: %0d placed, %0d dropped.",
               items_sent, settings_used, placed_count, dropped_count);
      $display("Covered margins, batch range, zero registers and address wrap.");
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire
